// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON key string unescaper
// Run record passed from the parser front end through the queue to the
// result serializer, plus the parser phase encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

  // Most output bytes one input byte can cause
  localparam int RUN_MAX = 5;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

  // Reset value of the output length register
  localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_BODY   = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  // Everything one input byte produced
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    count;
    logic                    ended;
    logic                    found;
  } run_t;

endpackage

// ----- src/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front: key search and string unescape front end
// Takes one response byte per request, tracks the key match and the escape
// state, and produces the run of output bytes that byte causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     max_len,
  input  logic            take,
  input  logic [7:0]      in_byte,
  input  logic            end_of_response,
  output logic            push,
  output jsu_pkg::run_t   run
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [3:0] KEY_LEN = 4'd15;

  // "plainLyrics":"
  localparam logic [7:0] KEY_TEXT [15] = '{
    8'h22, 8'h70, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h4C, 8'h79,
    8'h72, 8'h69, 8'h63, 8'h73, 8'h22, 8'h3A, 8'h22
  };

  // {valid, nibble} of an ASCII hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39)      r = {1'b1, 4'(ch - 8'h30)};
    else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
    else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
    return r;
  endfunction

  jsu_pkg::phase_t phase, phase_next;
  logic [3:0]  kidx, kidx_next;
  logic        esc, esc_next;
  logic        uni, uni_next;
  logic [1:0]  hcnt, hcnt_next;
  logic [11:0] hacc, hacc_next;
  logic [7:0]  held [3];
  logic [7:0]  held_next [3];
  logic [9:0]  hsb, hsb_next;
  logic        hsv, hsv_next;
  logic [15:0] emit_cnt, emit_cnt_next;
  logic        key_seen, key_seen_next;

  // Room left before the limit: at limit after k more bytes when gap <= k
  logic signed [17:0] gap;
  logic [7:0]         lim_hit;

  always_comb begin
    gap = $signed({2'b00, max_len}) - 18'sd2 - $signed({2'b00, emit_cnt});
    for (int i = 0; i < 8; i++) begin
      lim_hit[i] = (gap <= $signed(18'(i)));
    end
  end

  // Per-byte next state and output run
  always_comb begin
    logic [2:0]  e;
    logic        fin;
    logic [7:0]  b;
    logic        do_plain;
    logic        pre_u;
    logic [1:0]  pk;
    logic [7:0]  po;
    logic [7:0]  ph [4];
    logic [4:0]  hx;
    logic [3:0]  kidx_m;
    logic [15:0] v;
    logic [20:0] cp;

    phase_next    = phase;
    kidx_next     = kidx;
    esc_next      = esc;
    uni_next      = uni;
    hcnt_next     = hcnt;
    hacc_next     = hacc;
    held_next     = held;
    hsb_next      = hsb;
    hsv_next      = hsv;
    emit_cnt_next = emit_cnt;
    key_seen_next = key_seen;
    run           = '0;
    e             = 3'd0;
    fin           = 1'b0;
    b             = CH_NUL;
    do_plain      = 1'b0;
    pre_u         = 1'b0;
    pk            = 2'd0;
    po            = in_byte;
    hx            = hex_val(in_byte);
    kidx_m        = 4'd0;
    v             = {hacc, hx[3:0]};
    cp            = 21'h10000 + {1'b0, hsb, v[9:0]};

    case (phase)
      jsu_pkg::PH_SEARCH: begin
        if (in_byte == CH_NUL) begin
          fin           = 1'b1;
          key_seen_next = 1'b0;
        end else begin
          if (in_byte == KEY_TEXT[kidx])                 kidx_m = kidx + 4'd1;
          else if (in_byte == CH_QUOTE)                  kidx_m = 4'd1;
          else if (kidx == 4'd13 && in_byte == CH_P)     kidx_m = 4'd2;
          else                                           kidx_m = 4'd0;
          if (kidx_m == KEY_LEN) begin
            kidx_next     = 4'd0;
            key_seen_next = 1'b1;
            phase_next    = jsu_pkg::PH_BODY;
            esc_next      = 1'b0;
            uni_next      = 1'b0;
            hcnt_next     = 2'd0;
            hsv_next      = 1'b0;
            emit_cnt_next = 16'd0;
            if (max_len < 16'd3) fin = 1'b1;
          end else begin
            kidx_next = kidx_m;
          end
        end
      end
      jsu_pkg::PH_BODY: begin
        if (uni) begin
          if (hx[4]) begin
            if (hcnt == 2'd3) begin
              // Fourth digit: decode the code unit
              uni_next  = 1'b0;
              hcnt_next = 2'd0;
              hsv_next  = 1'b0;
              if (hsv && v >= 16'hDC00 && v <= 16'hDFFF) begin
                if (!lim_hit[2]) begin
                  run.bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
                  run.bytes[1] = {2'b10, cp[17:12]};
                  run.bytes[2] = {2'b10, cp[11:6]};
                  run.bytes[3] = {2'b10, cp[5:0]};
                  e = 3'd4;
                end
                if (lim_hit[e]) fin = 1'b1;
              end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
                hsb_next = v[9:0];
                hsv_next = 1'b1;
              end else if (!(v >= 16'hDC00 && v <= 16'hDFFF)) begin
                if (v < 16'h0080) begin
                  if (!gap[17]) begin
                    run.bytes[0] = v[7:0];
                    e = 3'd1;
                  end
                end else if (v < 16'h0800) begin
                  if (!lim_hit[0]) begin
                    run.bytes[0] = {3'b110, v[10:6]};
                    run.bytes[1] = {2'b10, v[5:0]};
                    e = 3'd2;
                  end
                end else if (!lim_hit[1]) begin
                  run.bytes[0] = {4'b1110, v[15:12]};
                  run.bytes[1] = {2'b10, v[11:6]};
                  run.bytes[2] = {2'b10, v[5:0]};
                  e = 3'd3;
                end
                if (lim_hit[e]) fin = 1'b1;
              end
            end else begin
              // Collect a digit; end of response here makes it malformed
              held_next[hcnt] = in_byte;
              hacc_next       = {hacc[7:0], hx[3:0]};
              hcnt_next       = hcnt + 2'd1;
              if (end_of_response) begin
                do_plain = 1'b1;
                pre_u    = 1'b1;
                pk       = hcnt + 2'd1;
                po       = CH_NUL;
                hsv_next = 1'b0;
              end
            end
          end else begin
            // Malformed escape: 'u', the digits so far, then this byte
            do_plain  = 1'b1;
            pre_u     = 1'b1;
            pk        = hcnt;
            uni_next  = 1'b0;
            hcnt_next = 2'd0;
            hsv_next  = 1'b0;
          end
        end else if (esc) begin
          esc_next = 1'b0;
          if (in_byte != CH_U) hsv_next = 1'b0;
          if (in_byte == CH_NUL) begin
            fin = 1'b1;
          end else if (in_byte == CH_U) begin
            uni_next  = 1'b1;
            hcnt_next = 2'd0;
            if (end_of_response) begin
              do_plain = 1'b1;
              pre_u    = 1'b1;
              po       = CH_NUL;
            end
          end else begin
            if (in_byte == CH_N)      run.bytes[0] = CH_LF;
            else if (in_byte == CH_T) run.bytes[0] = CH_SP;
            else                      run.bytes[0] = in_byte;
            if (in_byte != CH_R) e = 3'd1;
            if (lim_hit[e]) fin = 1'b1;
          end
        end else begin
          do_plain = 1'b1;
          if (in_byte != CH_BSL) hsv_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Plain byte sequence: optional 'u', replayed digits, then one byte
    ph[0] = held_next[0];
    ph[1] = held_next[1];
    ph[2] = held_next[2];
    ph[3] = CH_NUL;
    if (do_plain) begin
      if (pre_u) begin
        run.bytes[e] = CH_U;
        e = e + 3'd1;
      end
      for (int i = 0; i < 4; i++) begin
        if (!fin && i <= int'(pk)) begin
          b = (i == int'(pk)) ? po : ph[2'(i)];
          if (lim_hit[e] || b == CH_NUL) begin
            fin = 1'b1;
          end else if (b == CH_BSL) begin
            esc_next = 1'b1;
          end else if (b == CH_QUOTE) begin
            fin = 1'b1;
          end else begin
            if (e < 3'(jsu_pkg::RUN_MAX)) run.bytes[e] = b;
            e = e + 3'd1;
            if (lim_hit[e]) fin = 1'b1;
          end
        end
      end
    end

    // End of response always closes an open string
    if (end_of_response && phase != jsu_pkg::PH_DONE) fin = 1'b1;

    if (fin) begin
      phase_next = jsu_pkg::PH_DONE;
      esc_next   = 1'b0;
      uni_next   = 1'b0;
      hsv_next   = 1'b0;
    end
    emit_cnt_next = emit_cnt_next + 16'(e);

    run.count = e;
    run.ended = fin;
    run.found = fin && key_seen_next;
    push      = take && (e != 3'd0 || fin);

    // Rearm for the next response
    if (end_of_response) begin
      phase_next    = jsu_pkg::PH_SEARCH;
      kidx_next     = 4'd0;
      esc_next      = 1'b0;
      uni_next      = 1'b0;
      hcnt_next     = 2'd0;
      hsv_next      = 1'b0;
      emit_cnt_next = 16'd0;
      key_seen_next = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= jsu_pkg::PH_SEARCH;
      kidx     <= 4'd0;
      esc      <= 1'b0;
      uni      <= 1'b0;
      hcnt     <= 2'd0;
      hsv      <= 1'b0;
      emit_cnt <= 16'd0;
      key_seen <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      kidx     <= kidx_next;
      esc      <= esc_next;
      uni      <= uni_next;
      hcnt     <= hcnt_next;
      hsv      <= hsv_next;
      emit_cnt <= emit_cnt_next;
      key_seen <= key_seen_next;
    end
  end

  // Escape payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      hacc <= hacc_next;
      held <= held_next;
      hsb  <= hsb_next;
    end
  end

endmodule

// ----- src/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue: run queue between front end and serializer
// Small flop FIFO of run records so the parser keeps taking bytes while the
// serializer drains multi-byte runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::run_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output jsu_pkg::run_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  jsu_pkg::run_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [LW-1:0] level;

  assign full  = (level == LW'(DEPTH));
  assign avail = (level != '0);
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      level <= level + LW'(1);
      else if (pop && !push) level <= level - LW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ----- src/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Walks the run at the queue head and sends one result per cycle while
// result_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          avail,
  input  jsu_pkg::run_t head,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    data_byte,
  output logic          byte_valid,
  output logic          text_end,
  output logic          key_found,
  output logic          last_of_run
);

  logic [jsu_pkg::RUN_CNT_W-1:0] slot;
  logic [jsu_pkg::RUN_CNT_W-1:0] total;
  logic                          last;
  logic                          load;

  // An empty run still gives one end marker
  assign total = (head.count == '0) ? jsu_pkg::RUN_CNT_W'(1) : head.count;
  assign last  = (slot == total - jsu_pkg::RUN_CNT_W'(1));
  assign load  = avail && (!result_valid || !result_stall);
  assign pop   = load && last;

  // Output valid and position within the run
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      slot         <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      slot         <= last ? '0 : slot + jsu_pkg::RUN_CNT_W'(1);
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_byte   <= (head.count != '0) ? head.bytes[slot] : 8'h00;
      byte_valid  <= (head.count != '0);
      text_end    <= last && head.ended;
      key_found   <= last && head.found;
      last_of_run <= last;
    end
  end

endmodule

// ----- src/json_key_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// json_key_string_unescape_utf8: each taken byte's results pass through the
// run queue and a registered output stage. One input byte per cycle while the
// run queue has room; results leave at one per cycle while result_stall is low.
// Synchronous rst clears all control state and sets the length limit to 8192.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_key_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        feed_valid,
  output logic        feed_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_response,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        text_end,
  output logic        key_found,
  output logic        last_of_run
);

  logic [15:0]   max_output_length;
  logic          take;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_avail;
  jsu_pkg::run_t q_in;
  jsu_pkg::run_t q_head;

  // Output length register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_length <= jsu_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_output_length <= cfg_wr_data;
    end
  end

  assign feed_stall = q_full;
  assign take       = feed_valid && !feed_stall;

  // Parser front end
  jsu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .max_len         (max_output_length),
    .take            (take),
    .in_byte         (in_byte),
    .end_of_response (end_of_response),
    .push            (q_push),
    .run             (q_in)
  );

  // Run queue
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // Result serializer
  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (q_avail),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .text_end     (text_end),
    .key_found    (key_found),
    .last_of_run  (last_of_run)
  );

`ifndef SYNTH
  // End of string only on the last result of a run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && text_end |-> last_of_run)
    else $error("text_end without last_of_run");

  // Key status only reported with the end of string
  a_found_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && key_found |-> text_end)
    else $error("key_found without text_end");

  // A result without a byte is a bare end marker
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> text_end && (data_byte == 8'h00))
    else $error("empty result that is not an end marker");
`endif

endmodule
